// ----- sv/shcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcm_pkg
// Shared types and constants of the soft/hard clip mixer pipeline.
// ----------------------------------------------------------------------------
package shcm_pkg;

  // Pipeline depth, input register to output register.
  localparam int STAGES = 7;

  // Tanh argument: unsigned Q.23, 4.0 sits at bit FRAC_W.
  localparam int FRAC_W = 25;
  localparam int ARG_W  = 40;

  localparam logic [15:0] Q15_ONE = 16'h8000;

  // Configuration register indexes.
  localparam logic [1:0] REG_CLIP_THR = 2'd0;
  localparam logic [1:0] REG_INV_CLIP = 2'd1;
  localparam logic [1:0] REG_DEPTH    = 2'd2;

  typedef struct packed {
    logic s1;
    logic s2;
  } shcm_adv2_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } shcm_adv3_t;

  // Segment lookup request: front end to tanh stage.
  typedef struct packed {
    logic              neg;
    logic [15:0]       hardm;
    logic              sat;
    logic [FRAC_W-1:0] frac;
  } shcm_seg_t;

  // Tanh result: tanh stage to mixer.
  typedef struct packed {
    logic        neg;
    logic [15:0] hardm;
    logic [15:0] tq;
  } shcm_tanh_t;

  // Restoring divide, evaluated at elaboration only to build constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ----- sv/shcm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcm_front
// Magnitude, hard clamp and tanh argument, then table segment and fraction.
// ----------------------------------------------------------------------------
module shcm_front #(
  parameter int SEGMENTS = 64
) (
  input  wire logic                               clk,
  input  wire shcm_pkg::shcm_adv2_t               adv,
  input  wire logic signed [15:0]                 sample,
  input  wire logic [15:0]                        clip_thr,
  input  wire logic [23:0]                        inv_clip,
  output      shcm_pkg::shcm_seg_t                seg,
  output      logic [$clog2(SEGMENTS+1)-1:0]      k
);

  localparam int KW = $clog2(SEGMENTS + 1);
  localparam int PW = shcm_pkg::FRAC_W + KW;

  logic [15:0]                raw;
  logic [15:0]                mag;
  logic                       s1_neg;
  logic [15:0]                s1_hardm;
  logic [shcm_pkg::ARG_W-1:0] s1_arg;
  logic [PW-1:0]              pos;

  // Full-scale negative input gives 0x8000, which is still the right magnitude.
  assign raw = sample;
  assign mag = sample[15] ? (16'd0 - raw) : raw;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_neg   <= sample[15];
      s1_hardm <= (mag < clip_thr) ? mag : clip_thr;
      s1_arg   <= shcm_pkg::ARG_W'(mag) * shcm_pkg::ARG_W'(inv_clip);
    end
  end

  assign pos = PW'(s1_arg[shcm_pkg::FRAC_W-1:0]) * PW'(SEGMENTS);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      seg.neg   <= s1_neg;
      seg.hardm <= s1_hardm;
      seg.sat   <= |s1_arg[shcm_pkg::ARG_W-1:shcm_pkg::FRAC_W];
      seg.frac  <= pos[shcm_pkg::FRAC_W-1:0];
      k         <= pos[PW-1:shcm_pkg::FRAC_W];
    end
  end

endmodule
`default_nettype wire

// ----- sv/shcm_tanh.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcm_tanh
// Tanh table read at both segment ends, then linear interpolation.
// ----------------------------------------------------------------------------
module shcm_tanh #(
  parameter int SEGMENTS = 64
) (
  input  wire logic                           clk,
  input  wire shcm_pkg::shcm_adv2_t           adv,
  input  wire shcm_pkg::shcm_seg_t            seg,
  input  wire logic [$clog2(SEGMENTS+1)-1:0]  k,
  output      shcm_pkg::shcm_tanh_t           tanh_res
);

  localparam int KW    = $clog2(SEGMENTS + 1);
  localparam int TAB_W = (SEGMENTS + 1) * 16;
  localparam int MW    = shcm_pkg::FRAC_W + 16;

  // Entry k is tanh(4k/SEGMENTS) in Q1.15, stepped with the tanh addition
  // formula in Q30 from tanh(h) taken from its odd series.
  function automatic logic [TAB_W-1:0] build_table(input int segs);
    logic [63:0]      h;
    logic [63:0]      h2;
    logic [63:0]      h3;
    logic [63:0]      h5;
    logic [63:0]      h7;
    logic [63:0]      h9;
    logic [63:0]      th;
    logic [63:0]      t;
    logic [63:0]      q;
    logic [63:0]      den;
    logic [63:0]      num;
    logic [TAB_W-1:0] tab;
    tab = '0;
    h   = shcm_pkg::udiv64(64'h1_0000_0000, 64'(segs));
    h2  = (h * h) >> 30;
    h3  = (h * h2) >> 30;
    h5  = (h3 * h2) >> 30;
    h7  = (h5 * h2) >> 30;
    h9  = (h7 * h2) >> 30;
    th  = h + (64'd2 * h5) / 64'd15 + (64'd62 * h9) / 64'd2835
          - h3 / 64'd3 - (64'd17 * h7) / 64'd315;
    t   = '0;
    for (int i = 0; i <= segs; i++) begin
      q = (t + 64'h4000) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      tab[i*16 +: 16] = q[15:0];
      den = 64'h4000_0000 + ((t * th + 64'h2000_0000) >> 30);
      num = (t + th) << 30;
      t   = shcm_pkg::udiv64(num + (den >> 1), den);
    end
    return tab;
  endfunction

  localparam logic [TAB_W-1:0] TANH_TAB = build_table(SEGMENTS);

  logic [KW-1:0]              k_hi;
  logic [15:0]                lo;
  logic [15:0]                hi;
  logic                       s3_neg;
  logic                       s3_sat;
  logic [15:0]                s3_hardm;
  logic [shcm_pkg::FRAC_W-1:0] s3_frac;
  logic [15:0]                diff;
  logic [MW-1:0]              prod;
  logic [MW-1:0]              prod_rnd;
  logic [15:0]                interp;

  // Segment index stays below SEGMENTS, so k + 1 is still in the table.
  assign k_hi = k + 1'b1;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      lo       <= TANH_TAB[{k, 4'd0} +: 16];
      hi       <= TANH_TAB[{k_hi, 4'd0} +: 16];
      s3_neg   <= seg.neg;
      s3_sat   <= seg.sat;
      s3_hardm <= seg.hardm;
      s3_frac  <= seg.frac;
    end
  end

  assign diff     = (hi < lo) ? 16'd0 : (hi - lo);
  assign prod     = MW'(diff) * MW'(s3_frac);
  assign prod_rnd = prod + (MW'(1) << (shcm_pkg::FRAC_W - 1));
  assign interp   = lo + prod_rnd[shcm_pkg::FRAC_W +: 16];

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      tanh_res.neg   <= s3_neg;
      tanh_res.hardm <= s3_hardm;
      tanh_res.tq    <= s3_sat ? shcm_pkg::Q15_ONE : interp;
    end
  end

endmodule
`default_nettype wire

// ----- sv/shcm_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shcm_mix
// Soft and hard magnitudes weighted by depth, rounded, signed and saturated.
// ----------------------------------------------------------------------------
module shcm_mix (
  input  wire logic                  clk,
  input  wire shcm_pkg::shcm_adv3_t  adv,
  input  wire shcm_pkg::shcm_tanh_t  tanh_res,
  input  wire logic [15:0]           clip_thr,
  input  wire logic [15:0]           depth,
  output      logic signed [15:0]    out_sample
);

  logic [31:0] soft_prod;
  logic [31:0] hard_prod;
  logic        s5_neg;
  logic [30:0] s5_soft;
  logic [30:0] s5_hard;
  logic [45:0] mix_prod;
  logic        s6_neg;
  logic [45:0] s6_soft;
  logic [30:0] s6_hard;
  logic [46:0] acc;
  logic [46:0] acc_rnd;
  logic [16:0] outm;
  logic [16:0] neg_mag;
  logic [16:0] neg_val;
  logic [15:0] out_next;

  assign soft_prod = 32'(clip_thr) * 32'(tanh_res.tq);
  assign hard_prod = 32'(shcm_pkg::Q15_ONE - depth) * 32'(tanh_res.hardm);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s5_neg  <= tanh_res.neg;
      s5_soft <= soft_prod[30:0];
      s5_hard <= hard_prod[30:0];
    end
  end

  assign mix_prod = 46'(depth) * 46'(s5_soft);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s6_neg  <= s5_neg;
      s6_soft <= mix_prod;
      s6_hard <= s5_hard;
    end
  end

  // Q45 sum, round half away from zero on the magnitude.
  assign acc     = 47'(s6_soft) + {1'b0, s6_hard, 15'd0};
  assign acc_rnd = acc + (47'd1 << 29);
  assign outm    = acc_rnd[46:30];
  assign neg_mag = (outm > 17'd32768) ? 17'd32768 : outm;
  assign neg_val = 17'd0 - neg_mag;

  always_comb begin
    if (s6_neg) begin
      out_next = neg_val[15:0];
    end else if (outm > 17'd32767) begin
      out_next = 16'h7FFF;
    end else begin
      out_next = outm[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      out_sample <= $signed(out_next);
    end
  end

endmodule
`default_nettype wire

// ----- sv/soft_hard_clip_mixer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soft_hard_clip_mixer_top
// Tanh soft clipper mixed with a hard clamp, one Q1.15 sample per beat.
// ----------------------------------------------------------------------------
// Takes one sample per clock while in_ready is high. A sample moves through the
// stages in order into the output register and leaves as an output beat when
// the output side does not stall. The seven register stages are: argument
// multiply, segment position, table read, interpolation, the two weight
// multiplies, the depth multiply, and the round/saturate into the output
// register. Every stage has its own valid bit and holds only while it is full
// and the stage after it holds, so empty stages still fill under an output
// stall. Write the clip threshold, inv_clip and depth only while no sample is
// in flight; clip threshold and depth above 32768 are stored as 32768.
// ----------------------------------------------------------------------------
module soft_hard_clip_mixer_top #(
  parameter int TANH_SEGMENTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] sample,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] out_sample,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  localparam int KW = $clog2(TANH_SEGMENTS + 1);
  localparam int ST = shcm_pkg::STAGES;

  logic [15:0]              clip_thr;
  logic [23:0]              inv_clip;
  logic [15:0]              depth;
  logic [15:0]              cfg_q15;
  logic [ST:1]              stage_valid;
  logic [ST:1]              valid_in;
  logic [ST+1:1]            en;
  shcm_pkg::shcm_adv2_t     front_adv;
  shcm_pkg::shcm_adv2_t     tanh_adv;
  shcm_pkg::shcm_adv3_t     mix_adv;
  shcm_pkg::shcm_seg_t      seg;
  logic [KW-1:0]            seg_k;
  shcm_pkg::shcm_tanh_t     tanh_res;

  assign cfg_q15 = (cfg_data[15:0] > shcm_pkg::Q15_ONE) ? shcm_pkg::Q15_ONE : cfg_data[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_thr <= shcm_pkg::Q15_ONE;
      inv_clip <= 24'd256;
      depth    <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shcm_pkg::REG_CLIP_THR: clip_thr <= cfg_q15;
        shcm_pkg::REG_INV_CLIP: inv_clip <= cfg_data;
        shcm_pkg::REG_DEPTH:    depth    <= cfg_q15;
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the next one advances.
  always_comb begin
    en[ST+1] = out_ready;
    for (int i = ST; i >= 1; i--) begin
      en[i] = !stage_valid[i] || en[i+1];
    end
  end

  assign valid_in = {stage_valid[ST-1:1], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= (en[ST:1] & valid_in) | (~en[ST:1] & stage_valid);
    end
  end

  assign in_ready  = en[1];
  assign out_valid = stage_valid[ST];

  assign front_adv = '{s1: en[1], s2: en[2]};
  assign tanh_adv  = '{s1: en[3], s2: en[4]};
  assign mix_adv   = '{s1: en[5], s2: en[6], s3: en[7]};

  shcm_front #(
    .SEGMENTS(TANH_SEGMENTS)
  ) u_front (
    .clk     (clk),
    .adv     (front_adv),
    .sample  (sample),
    .clip_thr(clip_thr),
    .inv_clip(inv_clip),
    .seg     (seg),
    .k       (seg_k)
  );

  shcm_tanh #(
    .SEGMENTS(TANH_SEGMENTS)
  ) u_tanh (
    .clk     (clk),
    .adv     (tanh_adv),
    .seg     (seg),
    .k       (seg_k),
    .tanh_res(tanh_res)
  );

  shcm_mix u_mix (
    .clk       (clk),
    .adv       (mix_adv),
    .tanh_res  (tanh_res),
    .clip_thr  (clip_thr),
    .depth     (depth),
    .out_sample(out_sample)
  );

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) rst |=> (stage_valid == '0))
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> stage_valid[1])
    else $error("accepted beat missing from first stage");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&stage_valid) && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  a_beat_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(stage_valid) == $past($countones(stage_valid))
      + ($past(in_valid && in_ready) ? 1 : 0) - ($past(out_valid && out_ready) ? 1 : 0)))
    else $error("beat lost or duplicated in pipeline");
`endif

endmodule
`default_nettype wire
